### hdl/multi_queue_checkin_engine_assert.svh
// Assertion macros for the checker file of the check-in engine.
`ifndef MULTI_QUEUE_CHECKIN_ENGINE_ASSERT_SVH
`define MULTI_QUEUE_CHECKIN_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, switched off in reset.
`define MQCE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, switched off in reset.
`define MQCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/mqce_pkg.sv
// Shared constants and types of the multi-queue check-in engine.
package mqce_pkg;

  // Default sizing
  localparam int NUM_QUEUES_DEF   = 16;
  localparam int POOL_ENTRIES_DEF = 256;
  localparam int TAG_BITS_DEF     = 32;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int QNUM_W   = 4;
  localparam int STATUS_W = 2;
  localparam int WAIT_W   = 9;
  localparam int CFG_W    = 5;

  // Queues in use after reset
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_REWIND  = 2'd1,
    CMD_NEXT    = 2'd2,
    CMD_CHECKIN = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_POOL_FULL = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

endpackage

### hdl/mqce_ram.sv
// Generic one-write, one-read RAM with registered read data.
module mqce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; a same-address read returns old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/multi_queue_checkin_engine.sv
// Top level of the multi-queue check-in engine: queue bank over a shared linked pool.
//
//   channel  | handshake                 | word
//   ---------+---------------------------+-------------------------------------------
//   cfg      | cfg_valid_i / cfg_ready_o | cfg_data_i (queues in use)
//   in       | in_valid_i  / in_ready_o  | command_i, counter_index_i, passenger_tag_i
//   out      | out_valid_o / out_ready_i | status_o, queue_number_o, item_tag_o,
//            |                           | waiting_count_o, last_o
//
// Enqueue, rewind and a refused command finish in S_EXEC, next goes on to S_NEXT2:
// every table sits in a one-write, one-read RAM with registered read, so each
// pointer hop waits for a read. Check-in skips empty queues and pops each non-empty one.
// No clearing pass after reset: the free list is served from a low-water mark.
// A word may wait in the output register while the next command is taken; the
// sequencer stalls only when it has a further word and that register is still full.
module multi_queue_checkin_engine
  import mqce_pkg::*;
#(
  parameter int NUM_QUEUES   = NUM_QUEUES_DEF,
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
  parameter int TAG_BITS     = TAG_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [QNUM_W-1:0]   counter_index_i,
  input  logic [TAG_BITS-1:0] passenger_tag_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [QNUM_W-1:0]   queue_number_o,
  output logic [TAG_BITS-1:0] item_tag_o,
  output logic [WAIT_W-1:0]   waiting_count_o,
  output logic                last_o
);

  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int IW = $clog2(NUM_QUEUES + 1);
  localparam int LW = (IW > CFG_W) ? IW : CFG_W;
  localparam int PW = $clog2(POOL_ENTRIES);
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam logic [LW-1:0] NQ_L   = LW'(NUM_QUEUES);
  localparam logic [CW-1:0] POOL_L = CW'(POOL_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_NEXT2,
    S_CI_SCAN,
    S_CI_HEAD,
    S_CI_POP,
    S_CI_END
  } state_e;

  // Sequencer and control state
  state_e              state_q, state_d;
  logic [CFG_W-1:0]    active_q, active_d;
  cmd_e                cmd_q, cmd_d;
  logic [QNUM_W-1:0]   q_q, q_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic [IW-1:0]       i_q, i_d;
  logic [PW-1:0]       ent_q, ent_d;
  logic                at_tail_q, at_tail_d;
  logic [CW-1:0]       fc_q, fc_d;
  logic [CW-1:0]       lwm_q, lwm_d;
  logic [CW-1:0]       cnt_q [NUM_QUEUES];
  logic [CW-1:0]       cnt_d [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] cval_q, cval_d;

  // Check-in word held back until it is known whether it is the last
  logic                pend_valid_q, pend_valid_d;
  logic [QNUM_W-1:0]   pend_qn_q, pend_qn_d;
  logic [TAG_BITS-1:0] pend_tag_q, pend_tag_d;
  logic [WAIT_W-1:0]   pend_wait_q, pend_wait_d;

  // Output register
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [QNUM_W-1:0]   out_qn_q, out_qn_d;
  logic [TAG_BITS-1:0] out_tag_q, out_tag_d;
  logic [WAIT_W-1:0]   out_wait_q, out_wait_d;
  logic                out_last_q, out_last_d;

  // Word built this cycle
  logic                emit;
  status_e             e_status;
  logic [QNUM_W-1:0]   e_qn;
  logic [TAG_BITS-1:0] e_tag;
  logic [WAIT_W-1:0]   e_wait;
  logic                e_last;

  // RAM ports
  logic [QW-1:0]       q_raddr;
  logic [PW-1:0]       head_rd, tail_rd, cur_rd, link_rd, stk_rd;
  logic [TAG_BITS-1:0] tag_rd;
  logic                head_we, tail_we, cur_we, link_we, tag_we, stk_we;
  logic [PW-1:0]       head_wd, cur_wd;

  // Shared decode
  logic                accept, slot_free, bad, fresh, cval_sel;
  logic [LW-1:0]       lim;
  logic [QW-1:0]       qsel;
  logic [CW-1:0]       cnt_sel;
  logic [PW-1:0]       new_ent;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;

  assign lim      = (LW'(active_q) > NQ_L) ? NQ_L : LW'(active_q);
  assign bad      = LW'(q_q) >= lim;
  assign qsel     = (cmd_q == CMD_CHECKIN) ? i_q[QW-1:0] : QW'(q_q);
  assign q_raddr  = (state_q == S_IDLE) ? QW'(counter_index_i) : qsel;
  assign cnt_sel  = cnt_q[qsel];
  assign cval_sel = cval_q[qsel];

  // Entries below the low-water mark were never handed out and name themselves
  assign fresh   = (fc_q == lwm_q);
  assign new_ent = fresh ? PW'(fc_q - CW'(1)) : stk_rd;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    cmd_d        = cmd_q;
    q_d          = q_q;
    tag_d        = tag_q;
    i_d          = i_q;
    ent_d        = ent_q;
    at_tail_d    = at_tail_q;
    fc_d         = fc_q;
    lwm_d        = lwm_q;
    cnt_d        = cnt_q;
    cval_d       = cval_q;
    pend_valid_d = pend_valid_q;
    pend_qn_d    = pend_qn_q;
    pend_tag_d   = pend_tag_q;
    pend_wait_d  = pend_wait_q;

    emit     = 1'b0;
    e_status = ST_OK;
    e_qn     = q_q;
    e_tag    = '0;
    e_wait   = '0;
    e_last   = 1'b1;

    head_we = 1'b0;
    head_wd = new_ent;
    tail_we = 1'b0;
    cur_we  = 1'b0;
    cur_wd  = head_rd;
    link_we = 1'b0;
    tag_we  = 1'b0;
    stk_we  = 1'b0;

    if (cfg_valid_i) begin
      active_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_e'(command_i);
          q_d     = counter_index_i;
          tag_d   = passenger_tag_i;
          i_d     = '0;
          state_d = (cmd_e'(command_i) == CMD_CHECKIN) ? S_CI_SCAN : S_EXEC;
        end
      end

      // Single-queue commands, table reads already registered
      S_EXEC: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_wait  = WAIT_W'(cnt_sel);
          state_d = S_IDLE;
          if (bad) begin
            e_status = ST_BAD_INDEX;
            e_wait   = '0;
          end else begin
            case (cmd_q)
              CMD_ENQUEUE: begin
                if (fc_q == '0) begin
                  e_status = ST_POOL_FULL;
                end else begin
                  tag_we  = 1'b1;
                  tail_we = 1'b1;
                  if (cnt_sel == '0) begin
                    head_we = 1'b1;
                  end else begin
                    link_we = 1'b1;
                  end
                  cnt_d[qsel] = cnt_sel + CW'(1);
                  fc_d        = fc_q - CW'(1);
                  if (fresh) begin
                    lwm_d = lwm_q - CW'(1);
                  end
                  e_tag  = tag_q;
                  e_wait = WAIT_W'(cnt_sel + CW'(1));
                end
              end
              CMD_REWIND: begin
                cur_we       = 1'b1;
                cval_d[qsel] = (cnt_sel != '0);
              end
              CMD_NEXT: begin
                if (!cval_sel) begin
                  e_status = ST_EMPTY;
                end else begin
                  emit      = 1'b0;
                  ent_d     = cur_rd;
                  at_tail_d = (cnt_sel != '0) && (cur_rd == tail_rd);
                  state_d   = S_NEXT2;
                end
              end
              default: begin
                state_d = S_IDLE;
              end
            endcase
          end
        end
      end

      // Next: tag and link of the cursor entry are in
      S_NEXT2: begin
        if (slot_free) begin
          emit   = 1'b1;
          e_tag  = tag_rd;
          e_wait = WAIT_W'(cnt_sel);
          if (at_tail_q) begin
            cval_d[qsel] = 1'b0;
          end else begin
            cur_we = 1'b1;
            cur_wd = link_rd;
          end
          if (cnt_sel == '0) begin
            cval_d[qsel] = 1'b0;
          end
          state_d = S_IDLE;
        end
      end

      // Check-in walk: skip empty queues, stop at the limit
      S_CI_SCAN: begin
        if (LW'(i_q) >= lim) begin
          state_d = S_CI_END;
        end else if (cnt_sel == '0) begin
          i_d = i_q + IW'(1);
        end else begin
          state_d = S_CI_HEAD;
        end
      end

      // Head entry known: free it and drop a cursor that sits on it
      S_CI_HEAD: begin
        ent_d  = head_rd;
        stk_we = 1'b1;
        fc_d   = fc_q + CW'(1);
        if (cval_sel && (cur_rd == head_rd)) begin
          cval_d[qsel] = 1'b0;
        end
        state_d = S_CI_POP;
      end

      // Unlink the head; the previous pop goes out as a non-final word
      S_CI_POP: begin
        if (!pend_valid_q || slot_free) begin
          if (pend_valid_q) begin
            emit   = 1'b1;
            e_qn   = pend_qn_q;
            e_tag  = pend_tag_q;
            e_wait = pend_wait_q;
            e_last = 1'b0;
          end
          head_we      = 1'b1;
          head_wd      = link_rd;
          cnt_d[qsel]  = cnt_sel - CW'(1);
          pend_valid_d = 1'b1;
          pend_qn_d    = QNUM_W'(i_q);
          pend_tag_d   = tag_rd;
          pend_wait_d  = WAIT_W'(cnt_sel - CW'(1));
          i_d          = i_q + IW'(1);
          state_d      = S_CI_SCAN;
        end
      end

      // Final word: the held pop, or nothing found
      S_CI_END: begin
        if (slot_free) begin
          emit = 1'b1;
          if (pend_valid_q) begin
            e_qn   = pend_qn_q;
            e_tag  = pend_tag_q;
            e_wait = pend_wait_q;
          end else begin
            e_status = ST_EMPTY;
            e_qn     = '0;
          end
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register next value
  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_qn_d     = out_qn_q;
    out_tag_d    = out_tag_q;
    out_wait_d   = out_wait_q;
    out_last_d   = out_last_q;
    if (emit) begin
      out_valid_d  = 1'b1;
      out_status_d = e_status;
      out_qn_d     = e_qn;
      out_tag_d    = e_tag;
      out_wait_d   = e_wait;
      out_last_d   = e_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      active_q     <= ACTIVE_RESET;
      cmd_q        <= CMD_ENQUEUE;
      q_q          <= '0;
      tag_q        <= '0;
      i_q          <= '0;
      ent_q        <= '0;
      at_tail_q    <= 1'b0;
      fc_q         <= POOL_L;
      lwm_q        <= POOL_L;
      cnt_q        <= '{default: '0};
      cval_q       <= '0;
      pend_valid_q <= 1'b0;
      pend_qn_q    <= '0;
      pend_tag_q   <= '0;
      pend_wait_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_qn_q     <= '0;
      out_tag_q    <= '0;
      out_wait_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      active_q     <= active_d;
      cmd_q        <= cmd_d;
      q_q          <= q_d;
      tag_q        <= tag_d;
      i_q          <= i_d;
      ent_q        <= ent_d;
      at_tail_q    <= at_tail_d;
      fc_q         <= fc_d;
      lwm_q        <= lwm_d;
      cnt_q        <= cnt_d;
      cval_q       <= cval_d;
      pend_valid_q <= pend_valid_d;
      pend_qn_q    <= pend_qn_d;
      pend_tag_q   <= pend_tag_d;
      pend_wait_q  <= pend_wait_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_qn_q     <= out_qn_d;
      out_tag_q    <= out_tag_d;
      out_wait_q   <= out_wait_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign queue_number_o  = out_qn_q;
  assign item_tag_o      = out_tag_q;
  assign waiting_count_o = out_wait_q;
  assign last_o          = out_last_q;

  // Per-queue pointer tables
  mqce_ram #(.WIDTH(PW), .DEPTH(NUM_QUEUES)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (qsel),
    .wdata_i (head_wd),
    .raddr_i (q_raddr),
    .rdata_o (head_rd)
  );

  mqce_ram #(.WIDTH(PW), .DEPTH(NUM_QUEUES)) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (tail_we),
    .waddr_i (qsel),
    .wdata_i (new_ent),
    .raddr_i (q_raddr),
    .rdata_o (tail_rd)
  );

  mqce_ram #(.WIDTH(PW), .DEPTH(NUM_QUEUES)) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cur_we),
    .waddr_i (qsel),
    .wdata_i (cur_wd),
    .raddr_i (q_raddr),
    .rdata_o (cur_rd)
  );

  // Pool: links, tags and the free stack
  mqce_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (tail_rd),
    .wdata_i (new_ent),
    .raddr_i (ent_d),
    .rdata_o (link_rd)
  );

  mqce_ram #(.WIDTH(TAG_BITS), .DEPTH(POOL_ENTRIES)) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_we),
    .waddr_i (new_ent),
    .wdata_i (tag_q),
    .raddr_i (ent_d),
    .rdata_o (tag_rd)
  );

  mqce_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (PW'(fc_q)),
    .wdata_i (head_rd),
    .raddr_i (PW'(fc_q - CW'(1))),
    .rdata_o (stk_rd)
  );

endmodule

### hdl/mqce_checker.sv
// Port-level checker of the multi-queue check-in engine, bound to the top level.
`include "multi_queue_checkin_engine_assert.svh"

module mqce_checker
  import mqce_pkg::*;
#(
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_o,
  input logic [QNUM_W-1:0]   queue_number_o,
  input logic [TAG_BITS-1:0] item_tag_o,
  input logic [WAIT_W-1:0]   waiting_count_o,
  input logic                last_o
);

  // Whole result word and handshake terms
  logic [STATUS_W+QNUM_W+TAG_BITS+WAIT_W:0] out_word;
  logic stalled, took_in, partial, refused;

  assign out_word = {status_o, queue_number_o, item_tag_o, waiting_count_o, last_o};
  assign stalled  = out_valid_o && !out_ready_i;
  assign took_in  = in_valid_i && in_ready_o;
  assign partial  = out_valid_o && !last_o;
  assign refused  = out_valid_o && ((status_o == ST_BAD_INDEX) || (status_o == ST_POOL_FULL));

  // A stalled result word holds
  `MQCE_ASSERT_NEXT(a_out_hold, stalled, out_valid_o && $stable(out_word), "stalled word changed")

  // One command at a time
  `MQCE_ASSERT_NEXT(a_busy_after_accept, took_in, !in_ready_o, "ready straight after a command")

  // A non-final check-in word means the walk is still running
  `MQCE_ASSERT_SAME(a_partial_busy, partial, !in_ready_o, "ready while a check-in is unfinished")

  // Refused commands answer with one final word and no tag
  `MQCE_ASSERT_SAME(a_refused_word, refused, last_o && (item_tag_o == '0), "bad refused word")

endmodule

bind multi_queue_checkin_engine mqce_checker #(.TAG_BITS(TAG_BITS)) u_mqce_checker (.*);
